[rtl/cpio_pkg.sv]
// Shared types and constants for the cpio newc stream deframer.
`default_nettype none
package cpio_pkg;
    localparam int unsigned QueueDepth = 4;
    localparam logic [23:0] MagicA = 24'h070701;
    localparam logic [23:0] MagicB = 24'h070702;
    localparam logic [6:0] HdrLast = 7'd109;

    typedef enum logic [2:0] {
        CLS_HEADER = 3'd0,
        CLS_NAME   = 3'd1,
        CLS_PAD    = 3'd2,
        CLS_DATA   = 3'd3,
        CLS_DONE   = 3'd4,
        CLS_ERROR  = 3'd5
    } t_class;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_MAGIC = 2'd1,
        ERR_HEX   = 2'd2,
        ERR_NAME0 = 2'd3
    } t_err;

    localparam logic [1:0] KindDir = 2'd0;
    localparam logic [1:0] KindLink = 2'd1;
    localparam logic [1:0] KindReg = 2'd2;

    // One classified beat, as carried from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic [2:0]  cls;
        logic        hdr_ready;
        logic [1:0]  kind;
        logic [11:0] perm;
        logic [31:0] name_len;
        logic [31:0] file_len;
        logic        name_last;
        logic        trailer;
        logic        dot;
        logic        rec_end;
        logic [1:0]  err;
    } t_beat;

    // Hex digit decode; bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h37);
        return d;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = 8'h54;
            4'd1: c = 8'h52;
            4'd2: c = 8'h41;
            4'd3: c = 8'h49;
            4'd4: c = 8'h4C;
            4'd5: c = 8'h45;
            4'd6: c = 8'h52;
            4'd7, 4'd8, 4'd9: c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

[rtl/cpio_front.sv]
// Front end: per-byte parse and classification of the archive stream.
`default_nettype none
module cpio_front import cpio_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic [7:0] i_byte,
    output t_beat       o_beat
);
    typedef enum logic [2:0] {
        PH_HEADER, PH_NAME, PH_NAMEPAD, PH_DATA, PH_DATAPAD, PH_DONE, PH_ERROR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_mode, n_mode;
    logic [31:0] r_nsz, n_nsz;
    logic [31:0] r_fsz, n_fsz;
    logic [1:0]  r_off;
    logic        r_trl, n_trl;
    logic        r_dot, n_dot;
    logic [1:0]  r_err, n_err;

    logic [1:0]  off_next;
    logic        parsed, first_dig, trl, dot;
    logic [4:0]  dig;
    logic [31:0] acc_v;
    t_beat       b;

    assign off_next = r_off + 2'd1;
    assign dig = hex_digit(i_byte);
    assign parsed = (r_cnt < 32'd6) || (r_cnt >= 32'd14 && r_cnt <= 32'd21) ||
                    (r_cnt >= 32'd54 && r_cnt <= 32'd61) ||
                    (r_cnt >= 32'd94 && r_cnt <= 32'd101);
    assign first_dig = (r_cnt == 32'd0) || (r_cnt == 32'd14) ||
                       (r_cnt == 32'd54) || (r_cnt == 32'd94);
    assign acc_v = first_dig ? {28'd0, dig[3:0]} : {r_acc[27:0], dig[3:0]};
    assign trl = r_trl && (r_nsz >= 32'd11);
    assign dot = r_dot && (r_nsz >= 32'd2);

    // Next-state and beat classification
    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_acc = r_acc; n_mode = r_mode;
        n_nsz = r_nsz; n_fsz = r_fsz; n_trl = r_trl; n_dot = r_dot; n_err = r_err;
        b = '0;
        b.data = i_byte;
        case (r_phase)
            PH_HEADER: begin
                b.cls = CLS_HEADER;
                if (parsed && dig[4]) begin
                    n_err = ERR_HEX; n_phase = PH_ERROR;
                end else if (parsed && r_cnt == 32'd5 && acc_v[23:0] != MagicA &&
                             acc_v[23:0] != MagicB) begin
                    n_err = ERR_MAGIC; n_phase = PH_ERROR;
                end else if (parsed && r_cnt == 32'd101 && acc_v == 32'd0) begin
                    n_err = ERR_NAME0; n_phase = PH_ERROR;
                end else begin
                    if (parsed) n_acc = acc_v;
                    if (r_cnt == 32'd21) n_mode = acc_v[15:0];
                    if (r_cnt == 32'd61) n_fsz = acc_v;
                    if (r_cnt == 32'd101) n_nsz = acc_v;
                    if (r_cnt == {25'd0, HdrLast}) begin
                        b.hdr_ready = 1'b1;
                        if ((r_mode & 16'o170000) == 16'o040000) b.kind = KindDir;
                        else if ((r_mode & 16'o120000) == 16'o120000) b.kind = KindLink;
                        else b.kind = KindReg;
                        b.perm = r_mode[11:0];
                        b.name_len = r_nsz;
                        b.file_len = r_fsz;
                        n_phase = PH_NAME; n_cnt = '0; n_trl = 1'b1; n_dot = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 32'd1;
                    end
                end
            end
            PH_NAME: begin
                b.cls = CLS_NAME;
                if (r_cnt != r_nsz - 32'd1 && r_cnt < r_nsz) begin
                    if (r_cnt < 32'd11 && i_byte != trailer_char(r_cnt[3:0]))
                        n_trl = 1'b0;
                    if (r_cnt == 32'd0 && i_byte != 8'h2E) n_dot = 1'b0;
                    if (r_cnt == 32'd1 && i_byte != 8'h00) n_dot = 1'b0;
                    n_cnt = r_cnt + 32'd1;
                end else begin
                    b.name_last = 1'b1; b.trailer = trl; b.dot = dot;
                    n_cnt = '0;
                    if (trl) begin
                        b.rec_end = 1'b1; n_phase = PH_DONE;
                    end else if (off_next == 2'd0) begin
                        b.rec_end = (r_fsz == 32'd0);
                        n_phase = (r_fsz == 32'd0) ? PH_HEADER : PH_DATA;
                    end else begin
                        n_phase = PH_NAMEPAD;
                    end
                end
            end
            PH_NAMEPAD: begin
                b.cls = CLS_PAD;
                if (off_next == 2'd0) begin
                    b.rec_end = (r_fsz == 32'd0);
                    n_phase = (r_fsz == 32'd0) ? PH_HEADER : PH_DATA;
                    n_cnt = '0;
                end
            end
            PH_DATA: begin
                b.cls = CLS_DATA;
                if (r_cnt + 32'd1 >= r_fsz || r_cnt == 32'hFFFF_FFFF) begin
                    n_cnt = '0;
                    if (off_next == 2'd0) begin
                        b.rec_end = 1'b1; n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_DATAPAD;
                    end
                end else begin
                    n_cnt = r_cnt + 32'd1;
                end
            end
            PH_DATAPAD: begin
                b.cls = CLS_PAD;
                if (off_next == 2'd0) begin
                    b.rec_end = 1'b1; n_phase = PH_HEADER; n_cnt = '0;
                end
            end
            PH_DONE: b.cls = CLS_DONE;
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
        if (n_phase == PH_ERROR) begin
            b = '0;
            b.data = i_byte;
            b.cls = CLS_ERROR;
            b.err = n_err;
        end
    end

    assign o_beat = b;

    // State registers, advanced per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_cnt <= '0; r_acc <= '0; r_mode <= '0;
            r_nsz <= '0; r_fsz <= '0; r_off <= '0; r_trl <= 1'b1; r_dot <= 1'b1;
            r_err <= ERR_NONE;
        end else if (i_valid) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_acc <= n_acc; r_mode <= n_mode;
            r_nsz <= n_nsz; r_fsz <= n_fsz; r_off <= off_next; r_trl <= n_trl;
            r_dot <= n_dot; r_err <= n_err;
        end
    end
endmodule
`default_nettype wire

[rtl/cpio_queue.sv]
// Back end: small FIFO holding classified beats until popped.
`default_nettype none
module cpio_queue import cpio_pkg::*; #(
    parameter int unsigned Depth = QueueDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_beat i_beat,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_beat      o_beat
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

    t_beat          r_mem [Depth];
    logic [Aw-1:0]  r_wp, r_rp;
    logic [Aw:0]    r_cnt;
    logic           do_push, do_pop;

    assign o_full = (r_cnt == (Aw+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_beat = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_beat;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + Aw'(1);
            if (do_pop) r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + Aw'(1);
            r_cnt <= r_cnt + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/cpio_newc_stream_deframer.sv]
// Top level of the cpio newc stream deframer.
//  channel | direction | handshake       | payload
//  input   | in        | i_push / o_full | i_in_byte
//  result  | out       | o_empty / i_pop | o_out_byte .. o_error_code
// One byte accepted per cycle while o_full is low; each beat is parsed in the
// cycle it is pushed and registered into the result FIFO.
// full rises only when the FIFO holds Depth (default QueueDepth) unpopped results.
// Synchronous active-low reset returns the parser to the header phase.
`default_nettype none
module cpio_newc_stream_deframer import cpio_pkg::*; #(
    parameter int unsigned Depth = QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_byte_class,
    output logic             o_header_ready,
    output logic [1:0]       o_entry_kind,
    output logic [11:0]      o_perm_bits,
    output logic [31:0]      o_name_length,
    output logic [31:0]      o_file_length,
    output logic             o_name_last,
    output logic             o_is_trailer,
    output logic             o_is_dot,
    output logic             o_record_end,
    output logic [1:0]       o_error_code
);
    t_beat fb, qb;
    logic  acc;

    assign acc = i_push && !o_full;

    cpio_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_byte(i_in_byte),
        .o_beat(fb)
    );

    cpio_queue #(.Depth(Depth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_beat(fb),
        .o_full(o_full), .i_pop(i_pop), .o_empty(o_empty), .o_beat(qb)
    );

    assign o_out_byte = qb.data;
    assign o_byte_class = qb.cls;
    assign o_header_ready = qb.hdr_ready;
    assign o_entry_kind = qb.kind;
    assign o_perm_bits = qb.perm;
    assign o_name_length = qb.name_len;
    assign o_file_length = qb.file_len;
    assign o_name_last = qb.name_last;
    assign o_is_trailer = qb.trailer;
    assign o_is_dot = qb.dot;
    assign o_record_end = qb.rec_end;
    assign o_error_code = qb.err;

    // Error beats carry a code, other beats none
    a_err_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_byte_class == CLS_ERROR) == (o_error_code != ERR_NONE)))
        else $error("error code and class disagree");
    // Decoded name length only on header-ready beats
    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_header_ready) |-> (o_name_length == 32'd0))
        else $error("name length outside header-ready beat");
    // Trailer flag implies name end and record end
    a_trl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_is_trailer) |-> (o_name_last && o_record_end))
        else $error("trailer flag without record end");
endmodule
`default_nettype wire
